// File: rtl/prm_pkg.sv
// prm_pkg: register map, reset values and shared widths for the pump run monitor
// depends on nothing; used by rtl/pump_run_monitor.sv and tb/tb_pump_run_monitor.sv
package prm_pkg;

    localparam int CUR_W  = 10;
    localparam int CNT_W  = 12;
    localparam int SEC_W  = 16;
    localparam int IDX_W  = 4;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_RUN_CURRENT   = 3'd0;
    localparam t_reg_idx REG_COUNT_CEILING = 3'd1;
    localparam t_reg_idx REG_ON_COUNT      = 3'd2;
    localparam t_reg_idx REG_OFF_COUNT     = 3'd3;
    localparam t_reg_idx REG_OVERCURRENT   = 3'd4;
    localparam t_reg_idx REG_RT_ALARM_LOW  = 3'd5;
    localparam t_reg_idx REG_RT_ALARM_HIGH = 3'd6;
    localparam t_reg_idx REG_MIN_REST      = 3'd7;

    localparam logic [CUR_W-1:0] RST_RUN_CURRENT   = 10'd50;
    localparam logic [CNT_W-1:0] RST_COUNT_CEILING = 12'd2500;
    localparam logic [CNT_W-1:0] RST_ON_COUNT      = 12'd2000;
    localparam logic [CNT_W-1:0] RST_OFF_COUNT     = 12'd10;
    localparam logic [CUR_W-1:0] RST_OVERCURRENT   = 10'd300;
    localparam logic [SEC_W-1:0] RST_RT_ALARM_LOW  = 16'd300;
    localparam logic [SEC_W-1:0] RST_RT_ALARM_HIGH = 16'd350;
    localparam logic [SEC_W-1:0] RST_MIN_REST      = 16'd4;

    localparam logic [SEC_W-1:0] SEC_MAX = {SEC_W{1'b1}};

endpackage

// File: rtl/pump_run_monitor.sv
// pump_run_monitor: run qualification, start/stop history and alarm latch
// depends on rtl/prm_pkg.sv (register map, reset values, widths)
//
// One current sample per word, one word per clock sustained. A word sits in an
// input register while the qualification counter, the run/rest second counters,
// both history shift registers, the start counter and the alarm latch are
// updated from it; the result word is written at that same edge into the output
// register, which drives o_out_valid. The state update is one pass of compares
// and small adds, so the next word can follow in the very next cycle. A stall on
// the output holds the result register and the input register and then stalls
// the input side. Configuration goes through an APB-style port, registers at byte
// addresses 4*i; the user must write them only while no word is in flight, and
// the block does not enforce this. The alarm latch is cleared only by reset. A
// history index at or beyond HISTORY_DEPTH reports zero.
module pump_run_monitor #(
    parameter int HISTORY_DEPTH = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // apb configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prm_pkg::ADDR_W-1:0]    paddr,
    input  logic [prm_pkg::DATA_W-1:0]    pwdata,
    output logic [prm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,

    // input word
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [prm_pkg::CUR_W-1:0]     i_current,
    input  logic                          i_second_tick,
    input  logic                          i_stored_alarm,
    input  logic [prm_pkg::IDX_W-1:0]     i_history_index,

    // result word
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_pump_running,
    output logic                          o_alarm,
    output logic                          o_store_alarm_request,
    output logic [prm_pkg::SEC_W-1:0]     o_start_count,
    output logic [prm_pkg::SEC_W-1:0]     o_on_time_at_index,
    output logic [prm_pkg::SEC_W-1:0]     o_off_time_at_index
);

    localparam int CUR_W = prm_pkg::CUR_W;
    localparam int CNT_W = prm_pkg::CNT_W;
    localparam int SEC_W = prm_pkg::SEC_W;
    localparam int IDX_W = prm_pkg::IDX_W;

    // configuration registers
    logic [CUR_W-1:0] r_run_current;
    logic [CNT_W-1:0] r_count_ceiling;
    logic [CNT_W-1:0] r_on_count;
    logic [CNT_W-1:0] r_off_count;
    logic [CUR_W-1:0] r_overcurrent;
    logic [SEC_W-1:0] r_rt_low;
    logic [SEC_W-1:0] r_rt_high;
    logic [SEC_W-1:0] r_min_rest;

    // input register
    logic             r_in_vld;
    logic [CUR_W-1:0] r_cur;
    logic             r_tick;
    logic             r_stored;
    logic [IDX_W-1:0] r_idx;

    // monitor state
    logic [CNT_W-1:0] r_qual;
    logic             r_running;
    logic [SEC_W-1:0] r_run_sec;
    logic [SEC_W-1:0] r_rest_sec;
    logic [SEC_W-1:0] r_run_hist  [HISTORY_DEPTH];
    logic [SEC_W-1:0] r_rest_hist [HISTORY_DEPTH];
    logic [SEC_W-1:0] r_starts;
    logic             r_alarm;

    // result register
    logic             r_out_vld;
    logic             r_o_running;
    logic             r_o_alarm;
    logic             r_o_store;
    logic [SEC_W-1:0] r_o_starts;
    logic [SEC_W-1:0] r_o_on_time;
    logic [SEC_W-1:0] r_o_off_time;

    // next values
    logic [CNT_W-1:0] n_qual;
    logic             n_running;
    logic [SEC_W-1:0] n_run_sec;
    logic [SEC_W-1:0] n_rest_sec;
    logic [SEC_W-1:0] n_run_hist  [HISTORY_DEPTH];
    logic [SEC_W-1:0] n_rest_hist [HISTORY_DEPTH];
    logic [SEC_W-1:0] n_starts;
    logic             n_alarm;
    logic             n_store;
    logic [SEC_W-1:0] n_on_time;
    logic [SEC_W-1:0] n_off_time;

    logic             adv;
    logic             load_in;
    logic             cfg_wr;
    prm_pkg::t_reg_idx cfg_sel;

    // ---------------------------------------------------------------- handshake
    // the input register moves into the result register when that one is free
    // or being taken in the same cycle
    assign adv         = r_in_vld && (!r_out_vld || !i_out_stall);
    assign load_in     = !r_in_vld || adv;
    assign o_in_stall  = !load_in;
    assign o_out_valid = r_out_vld;

    // ---------------------------------------------------------------- apb port
    assign pready  = 1'b1;
    assign cfg_sel = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_current   <= prm_pkg::RST_RUN_CURRENT;
            r_count_ceiling <= prm_pkg::RST_COUNT_CEILING;
            r_on_count      <= prm_pkg::RST_ON_COUNT;
            r_off_count     <= prm_pkg::RST_OFF_COUNT;
            r_overcurrent   <= prm_pkg::RST_OVERCURRENT;
            r_rt_low        <= prm_pkg::RST_RT_ALARM_LOW;
            r_rt_high       <= prm_pkg::RST_RT_ALARM_HIGH;
            r_min_rest      <= prm_pkg::RST_MIN_REST;
        end else if (cfg_wr) begin
            case (cfg_sel)
                prm_pkg::REG_RUN_CURRENT:   r_run_current   <= pwdata[CUR_W-1:0];
                prm_pkg::REG_COUNT_CEILING: r_count_ceiling <= pwdata[CNT_W-1:0];
                prm_pkg::REG_ON_COUNT:      r_on_count      <= pwdata[CNT_W-1:0];
                prm_pkg::REG_OFF_COUNT:     r_off_count     <= pwdata[CNT_W-1:0];
                prm_pkg::REG_OVERCURRENT:   r_overcurrent   <= pwdata[CUR_W-1:0];
                prm_pkg::REG_RT_ALARM_LOW:  r_rt_low        <= pwdata[SEC_W-1:0];
                prm_pkg::REG_RT_ALARM_HIGH: r_rt_high       <= pwdata[SEC_W-1:0];
                prm_pkg::REG_MIN_REST:      r_min_rest      <= pwdata[SEC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            prm_pkg::REG_RUN_CURRENT:   prdata = 32'(r_run_current);
            prm_pkg::REG_COUNT_CEILING: prdata = 32'(r_count_ceiling);
            prm_pkg::REG_ON_COUNT:      prdata = 32'(r_on_count);
            prm_pkg::REG_OFF_COUNT:     prdata = 32'(r_off_count);
            prm_pkg::REG_OVERCURRENT:   prdata = 32'(r_overcurrent);
            prm_pkg::REG_RT_ALARM_LOW:  prdata = 32'(r_rt_low);
            prm_pkg::REG_RT_ALARM_HIGH: prdata = 32'(r_rt_high);
            prm_pkg::REG_MIN_REST:      prdata = 32'(r_min_rest);
            default:                    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (load_in) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in && i_in_valid) begin
            r_cur    <= i_current;
            r_tick   <= i_second_tick;
            r_stored <= i_stored_alarm;
            r_idx    <= i_history_index;
        end
    end

    // ---------------------------------------------------------------- state update
    always_comb begin
        logic             up;
        logic             start;
        logic             stop;
        logic             q_on;
        logic             run_mid;
        logic [SEC_W-1:0] run_s;
        logic [SEC_W-1:0] rest_s;

        // second tick goes to whichever phase was in effect
        run_s  = r_run_sec;
        rest_s = r_rest_sec;
        if (r_tick) begin
            if (r_running) begin
                run_s = (r_run_sec == prm_pkg::SEC_MAX) ? r_run_sec : r_run_sec + 1'b1;
            end else begin
                rest_s = (r_rest_sec == prm_pkg::SEC_MAX) ? r_rest_sec : r_rest_sec + 1'b1;
            end
        end

        // qualification counter, saturating at zero; at or above the ceiling a high current counts it down
        up = (r_cur > r_run_current) && (r_qual < r_count_ceiling);
        if (up) begin
            n_qual = r_qual + 1'b1;
        end else if (r_qual != '0) begin
            n_qual = r_qual - 1'b1;
        end else begin
            n_qual = r_qual;
        end
        q_on = n_qual > r_on_count;

        n_run_hist  = r_run_hist;
        n_rest_hist = r_rest_hist;
        n_starts    = r_starts;

        // start: log the rest time, count the start
        start   = q_on && !r_running;
        run_mid = r_running;
        if (start) begin
            run_s          = '0;
            run_mid        = 1'b1;
            n_starts       = r_starts + 1'b1;
            n_rest_hist[0] = rest_s;
            for (int i = 1; i < HISTORY_DEPTH; i++) begin
                n_rest_hist[i] = r_rest_hist[i-1];
            end
        end

        // stop: log the run time (zero if it started in this same word)
        stop      = (n_qual < r_off_count) && run_mid;
        n_running = run_mid;
        if (stop) begin
            rest_s        = '0;
            n_running     = 1'b0;
            n_run_hist[0] = run_s;
            for (int i = 1; i < HISTORY_DEPTH; i++) begin
                n_run_hist[i] = r_run_hist[i-1];
            end
        end

        n_run_sec  = run_s;
        n_rest_sec = rest_s;

        // overcurrent alarm
        n_alarm = r_alarm || (q_on && (r_cur > r_overcurrent));

        // run time window alarm, also asks for a nonvolatile store
        n_store = !n_alarm && q_on && n_running &&
                  (run_s > r_rt_low) && (run_s < r_rt_high) &&
                  ((rest_s > r_min_rest) || r_stored);
        if (n_store) begin
            n_alarm = 1'b1;
        end

        // history readout after the update, zero past the end
        n_on_time  = '0;
        n_off_time = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (32'(r_idx) == i) begin
                n_on_time  = n_run_hist[i];
                n_off_time = n_rest_hist[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qual     <= '0;
            r_running  <= 1'b0;
            r_run_sec  <= '0;
            r_rest_sec <= '0;
            r_starts   <= '0;
            r_alarm    <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_run_hist[i]  <= '0;
                r_rest_hist[i] <= '0;
            end
        end else if (adv) begin
            r_qual      <= n_qual;
            r_running   <= n_running;
            r_run_sec   <= n_run_sec;
            r_rest_sec  <= n_rest_sec;
            r_starts    <= n_starts;
            r_alarm     <= n_alarm;
            r_run_hist  <= n_run_hist;
            r_rest_hist <= n_rest_hist;
        end
    end

    // ---------------------------------------------------------------- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_running  <= n_running;
            r_o_alarm    <= n_alarm;
            r_o_store    <= n_store;
            r_o_starts   <= n_starts;
            r_o_on_time  <= n_on_time;
            r_o_off_time <= n_off_time;
        end
    end

    assign o_pump_running        = r_o_running;
    assign o_alarm               = r_o_alarm;
    assign o_store_alarm_request = r_o_store;
    assign o_start_count         = r_o_starts;
    assign o_on_time_at_index    = r_o_on_time;
    assign o_off_time_at_index   = r_o_off_time;

endmodule

// File: tb/tb_pump_run_monitor.sv
// tb_pump_run_monitor: self-checking testbench for the pump run monitor, with an
// in-bench status predictor, randomized pacing on both word channels and apb setup
// depends on rtl/prm_pkg.sv and rtl/pump_run_monitor.sv
module tb_pump_run_monitor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CUR_W  = prm_pkg::CUR_W;
    localparam int CNT_W  = prm_pkg::CNT_W;
    localparam int SEC_W  = prm_pkg::SEC_W;
    localparam int IDX_W  = prm_pkg::IDX_W;
    localparam int ADDR_W = prm_pkg::ADDR_W;
    localparam int DATA_W = prm_pkg::DATA_W;

    localparam int HIST_DEPTH     = 10;
    localparam int SETTLE_CYCLES  = 4;     // settling margin after the last owed status
    localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int N_PHASES       = 11;
    localparam int PHASE_WORDS    = 130;
    localparam int DIR_N          = 19;

    // one input word
    typedef struct packed {
        logic [CUR_W-1:0] cur;
        logic             tick;
        logic             stored;
        logic [IDX_W-1:0] idx;
    } t_sample;

    // one result word
    typedef struct packed {
        logic             running;
        logic             alarm;
        logic             store_req;
        logic [SEC_W-1:0] starts;
        logic [SEC_W-1:0] on_time;
        logic [SEC_W-1:0] off_time;
    } t_status;

    // one full register setting
    typedef struct packed {
        logic [CUR_W-1:0] run_cur;
        logic [CNT_W-1:0] ceiling;
        logic [CNT_W-1:0] on_cnt;
        logic [CNT_W-1:0] off_cnt;
        logic [CUR_W-1:0] oc_limit;
        logic [SEC_W-1:0] rt_low;
        logic [SEC_W-1:0] rt_high;
        logic [SEC_W-1:0] rest_min;
    } t_cfg;

    // directed row: the word, whether a new setting goes in first, and whether
    // the expectation is the idle status typed in rather than predicted
    typedef struct packed {
        t_sample w;
        logic    reconf;
        logic    typed;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [CUR_W-1:0]    i_current;
    logic                i_second_tick;
    logic                i_stored_alarm;
    logic [IDX_W-1:0]    i_history_index;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_pump_running;
    logic                o_alarm;
    logic                o_store_alarm_request;
    logic [SEC_W-1:0]    o_start_count;
    logic [SEC_W-1:0]    o_on_time_at_index;
    logic [SEC_W-1:0]    o_off_time_at_index;

    pump_run_monitor #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_current             (i_current),
        .i_second_tick         (i_second_tick),
        .i_stored_alarm        (i_stored_alarm),
        .i_history_index       (i_history_index),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_pump_running        (o_pump_running),
        .o_alarm               (o_alarm),
        .o_store_alarm_request (o_store_alarm_request),
        .o_start_count         (o_start_count),
        .o_on_time_at_index    (o_on_time_at_index),
        .o_off_time_at_index   (o_off_time_at_index)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 0;
    end

    // predictor copy of the block's settings and state
    t_cfg             m_cfg;
    logic [CNT_W-1:0] m_qual;
    logic             m_running;
    logic [SEC_W-1:0] m_run_sec;
    logic [SEC_W-1:0] m_rest_sec;
    logic [SEC_W-1:0] m_run_hist  [HIST_DEPTH];
    logic [SEC_W-1:0] m_rest_hist [HIST_DEPTH];
    logic [SEC_W-1:0] m_starts;
    logic             m_alarm;

    t_status pump_status_q [$];   // statuses still owed by the block

    int  err_count    = 0;
    int  n_words      = 0;
    int  n_settings   = 0;
    int  n_store_reqs = 0;
    int  quiet_cycles = 0;
    int  hold_token   = 0;        // bumped to ask the receiver for a long hold-off
    bit  tx_steady    = 1'b0;     // sender offers back to back
    bit  rx_steady    = 1'b0;     // receiver never stalls

    // mismatch reporting: one line each, always counted
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
        err_count++;
    endtask

    function automatic t_cfg mk_cfg(input int rc, input int ceil_v, input int on_v,
                                    input int off_v, input int oc, input int lo,
                                    input int hi, input int mr);
        t_cfg c;
        c.run_cur  = CUR_W'(rc);
        c.ceiling  = CNT_W'(ceil_v);
        c.on_cnt   = CNT_W'(on_v);
        c.off_cnt  = CNT_W'(off_v);
        c.oc_limit = CUR_W'(oc);
        c.rt_low   = SEC_W'(lo);
        c.rt_high  = SEC_W'(hi);
        c.rest_min = SEC_W'(mr);
        return c;
    endfunction

    function automatic t_dir_row mk_row(input int cur, input bit tick, input bit stored,
                                        input int idx, input bit reconf, input bit typed);
        t_dir_row r;
        r.w.cur    = CUR_W'(cur);
        r.w.tick   = tick;
        r.w.stored = stored;
        r.w.idx    = IDX_W'(idx);
        r.reconf   = reconf;
        r.typed    = typed;
        return r;
    endfunction

    // status after one sample: tick, counter, start, stop, overcurrent, time alarm
    function automatic t_status advance_pump(input t_sample s);
        t_status st;
        int      i;
        st = '0;
        if (s.tick) begin
            if (m_running)
                m_run_sec = (m_run_sec == prm_pkg::SEC_MAX) ? m_run_sec : m_run_sec + 1'b1;
            else
                m_rest_sec = (m_rest_sec == prm_pkg::SEC_MAX) ? m_rest_sec
                                                              : m_rest_sec + 1'b1;
        end
        // up/down counter; at or above the ceiling a high current still drains it
        if (s.cur > m_cfg.run_cur && m_qual < m_cfg.ceiling)
            m_qual = m_qual + 1'b1;
        else if (m_qual != '0)
            m_qual = m_qual - 1'b1;
        // start: log the rest that just ended
        if (m_qual > m_cfg.on_cnt && !m_running) begin
            m_run_sec = '0;
            m_running = 1'b1;
            for (i = HIST_DEPTH - 1; i > 0; i--)
                m_rest_hist[i] = m_rest_hist[i-1];
            m_rest_hist[0] = m_rest_sec;
            m_starts = m_starts + 1'b1;
        end
        // stop: log the run that just ended, may follow a start in the same word
        if (m_qual < m_cfg.off_cnt && m_running) begin
            m_rest_sec = '0;
            m_running  = 1'b0;
            for (i = HIST_DEPTH - 1; i > 0; i--)
                m_run_hist[i] = m_run_hist[i-1];
            m_run_hist[0] = m_run_sec;
        end
        if (m_qual > m_cfg.on_cnt && s.cur > m_cfg.oc_limit)
            m_alarm = 1'b1;
        if (!m_alarm && m_qual > m_cfg.on_cnt && m_running &&
            m_run_sec > m_cfg.rt_low && m_run_sec < m_cfg.rt_high &&
            (m_rest_sec > m_cfg.rest_min || s.stored)) begin
            m_alarm      = 1'b1;
            st.store_req = 1'b1;
        end
        st.running = m_running;
        st.alarm   = m_alarm;
        st.starts  = m_starts;
        if (s.idx < HIST_DEPTH) begin
            st.on_time  = m_run_hist[s.idx];
            st.off_time = m_rest_hist[s.idx];
        end
        return st;
    endfunction

    // offer one word after a random gap; returns at the edge that takes it,
    // leaving valid high so a following word can go back to back
    task automatic push_word(input t_sample w, input bit typed);
        int      gap;
        int      r;
        t_status st;
        r = $urandom_range(0, 99);
        if (tx_steady)  gap = 0;
        else if (r < 55) gap = 0;
        else if (r < 85) gap = $urandom_range(1, 3);
        else if (r < 97) gap = $urandom_range(4, 12);
        else             gap = $urandom_range(20, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_current       <= w.cur;
        i_second_tick   <= w.tick;
        i_stored_alarm  <= w.stored;
        i_history_index <= w.idx;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        // taken at this edge
        st = advance_pump(w);
        if (st.store_req)
            n_store_reqs++;
        pump_status_q.push_back(typed ? t_status'('0) : st);
        n_words++;
    endtask

    // sender goes quiet until every owed status is back and the pipe is empty
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pump_status_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write: setup, access, then idle; upper data bits carry junk
    task automatic apb_write(input prm_pkg::t_reg_idx idx, input logic [31:0] val,
                             input int width);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() << width) | val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input t_cfg s);
        apb_write(prm_pkg::REG_RUN_CURRENT,   32'(s.run_cur),  CUR_W);
        apb_write(prm_pkg::REG_COUNT_CEILING, 32'(s.ceiling),  CNT_W);
        apb_write(prm_pkg::REG_ON_COUNT,      32'(s.on_cnt),   CNT_W);
        apb_write(prm_pkg::REG_OFF_COUNT,     32'(s.off_cnt),  CNT_W);
        apb_write(prm_pkg::REG_OVERCURRENT,   32'(s.oc_limit), CUR_W);
        apb_write(prm_pkg::REG_RT_ALARM_LOW,  32'(s.rt_low),   SEC_W);
        apb_write(prm_pkg::REG_RT_ALARM_HIGH, 32'(s.rt_high),  SEC_W);
        apb_write(prm_pkg::REG_MIN_REST,      32'(s.rest_min), SEC_W);
        m_cfg = s;
        n_settings++;
    endtask

    // result side: every accepted word is checked against the oldest owed status
    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pump_status_q.size() == 0) begin
                flag_mismatch("result word with nothing owed", 32'(o_start_count), 0);
            end else begin
                want = pump_status_q.pop_front();
                if (o_pump_running !== want.running)
                    flag_mismatch("pump_running", 32'(o_pump_running), 32'(want.running));
                if (o_alarm !== want.alarm)
                    flag_mismatch("alarm", 32'(o_alarm), 32'(want.alarm));
                if (o_store_alarm_request !== want.store_req)
                    flag_mismatch("store_alarm_request", 32'(o_store_alarm_request),
                                  32'(want.store_req));
                if (o_start_count !== want.starts)
                    flag_mismatch("start_count", 32'(o_start_count), 32'(want.starts));
                if (o_on_time_at_index !== want.on_time)
                    flag_mismatch("on_time_at_index", 32'(o_on_time_at_index),
                                  32'(want.on_time));
                if (o_off_time_at_index !== want.off_time)
                    flag_mismatch("off_time_at_index", 32'(o_off_time_at_index),
                                  32'(want.off_time));
            end
        end
    end

    // receiver pacing: random stalls, steady stretches, and the long hold-off
    initial begin : rx_pace
        int served;
        int len;
        int r;
        bit lvl;
        served = 0;
        forever begin
            if (hold_token != served) begin
                // hold off long enough for the block to fill and stall its input
                served = hold_token;
                lvl    = 1'b1;
                len    = HOLD_CYCLES;
            end else if (rx_steady) begin
                lvl = 1'b0;
                len = 1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    lvl = 1'b0;
                    len = $urandom_range(1, 8);
                end else if (r < 90) begin
                    lvl = 1'b1;
                    len = $urandom_range(1, 3);
                end else if (r < 98) begin
                    lvl = 1'b1;
                    len = $urandom_range(4, 12);
                end else begin
                    lvl = 1'b1;
                    len = $urandom_range(20, 60);
                end
            end
            i_out_stall <= lvl;
            repeat (len) @(posedge i_clk);
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_dir_row dir_rows [DIR_N];
        t_cfg     dir_cfg  [3];
        t_cfg     s;
        t_sample  w;
        int       i;
        int       k;
        int       ph;
        int       n;
        int       seg_left;
        int       on_v;
        bit       seg_high;

        // every input known from time zero, reset held low
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_in_valid      <= 1'b0;
        i_current       <= '0;
        i_second_tick   <= 1'b0;
        i_stored_alarm  <= 1'b0;
        i_history_index <= '0;

        // predictor starts from the reset state
        m_cfg = mk_cfg(prm_pkg::RST_RUN_CURRENT, prm_pkg::RST_COUNT_CEILING,
                       prm_pkg::RST_ON_COUNT, prm_pkg::RST_OFF_COUNT,
                       prm_pkg::RST_OVERCURRENT, prm_pkg::RST_RT_ALARM_LOW,
                       prm_pkg::RST_RT_ALARM_HIGH, prm_pkg::RST_MIN_REST);
        m_qual     = '0;
        m_running  = 1'b0;
        m_run_sec  = '0;
        m_rest_sec = '0;
        m_starts   = '0;
        m_alarm    = 1'b0;
        foreach (m_run_hist[j]) begin
            m_run_hist[j]  = '0;
            m_rest_hist[j] = '0;
        end

        // directed settings: small thresholds, ceiling below the counter, and
        // thresholds that allow a start and a stop in one word
        dir_cfg[0] = mk_cfg(100, 6,    3, 2,    1023, 0, 0, 0);
        dir_cfg[1] = mk_cfg(100, 1,    3, 2,    1023, 0, 0, 0);
        dir_cfg[2] = mk_cfg(100, 4095, 0, 4095, 1023, 0, 0, 0);

        // reset defaults first: counter far below on_count, so these all give the
        // idle status; index out of range included
        dir_rows[0]  = mk_row(0,    0, 0, 0,  0, 1);
        dir_rows[1]  = mk_row(1023, 1, 1, 15, 0, 1);
        dir_rows[2]  = mk_row(1023, 1, 0, 9,  0, 1);
        dir_rows[3]  = mk_row(50,   0, 1, 10, 0, 1);   // equal to run_current: falls
        dir_rows[4]  = mk_row(51,   1, 0, 0,  0, 1);
        dir_rows[5]  = mk_row(300,  0, 0, 3,  0, 1);   // equal to overcurrent limit
        // small thresholds: start, overcurrent at the limit, ticks while running
        dir_rows[6]  = mk_row(101,  1, 0, 0,  1, 0);
        dir_rows[7]  = mk_row(1023, 1, 1, 0,  0, 0);
        dir_rows[8]  = mk_row(100,  1, 0, 1,  0, 0);
        dir_rows[9]  = mk_row(200,  0, 0, 0,  0, 0);
        // ceiling dropped under the counter: high current still drains it to a stop
        dir_rows[10] = mk_row(1023, 1, 0, 0,  1, 0);
        dir_rows[11] = mk_row(1023, 0, 1, 0,  0, 0);
        dir_rows[12] = mk_row(1023, 1, 0, 0,  0, 0);
        dir_rows[13] = mk_row(500,  1, 0, 0,  0, 0);
        // start and stop in the same word
        dir_rows[14] = mk_row(0,    1, 0, 0,  1, 0);
        dir_rows[15] = mk_row(101,  1, 0, 0,  0, 0);
        dir_rows[16] = mk_row(101,  0, 1, 1,  0, 0);
        dir_rows[17] = mk_row(1023, 1, 0, 9,  0, 0);
        dir_rows[18] = mk_row(0,    0, 0, 15, 0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        k = 0;
        for (i = 0; i < DIR_N; i++) begin
            if (dir_rows[i].reconf) begin
                drain_results();
                apply_setting(dir_cfg[k]);
                k++;
            end
            push_word(dir_rows[i].w, dir_rows[i].typed);
        end

        // random phases, each under its own setting; alarm paths are kept shut
        // until the last two phases since the latch only clears on reset
        seg_high = 1'b0;
        for (ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            tx_steady = (ph == 2 || ph == 4 || ph == 7);
            rx_steady = (ph == 4 || ph == 7);
            case (ph)
                0: s = mk_cfg(100,  20,   12,   4,    1023, 0,     0,     0);
                1: s = mk_cfg(0,    4095, 8,    2,    1023, 0,     0,     0);
                2: s = mk_cfg(300,  30,   15,   6,    1023, 65535, 0,     0);
                3: s = mk_cfg(1023, 0,    0,    0,    1023, 0,     0,     0);
                4: s = mk_cfg(200,  4095, 4095, 0,    1023, 0,     0,     0);
                5: s = mk_cfg(100,  50,   0,    4095, 1023, 0,     0,     0);
                6: s = mk_cfg(100,  25,   6,    9,    1023, 0,     0,     0);
                9: s = mk_cfg(100,  40,   20,   5,    1023, 3,     65535, 65535);
                10: s = mk_cfg(100, 40,   20,   5,    0,    65535, 0,     0);
                default: begin
                    on_v = $urandom_range(1, 30);
                    s = mk_cfg($urandom_range(1, 1000), on_v + $urandom_range(0, 30),
                               on_v, $urandom_range(0, on_v), 1023,
                               $urandom_range(0, 65535), 0, $urandom_range(0, 65535));
                end
            endcase
            apply_setting(s);
            if (ph == 2)
                hold_token++;   // receiver sits out while the sender keeps offering
            if (ph == 9)
                s.rest_min = 16'd0;   // stored-alarm path: the block keeps min rest 65535, which rest can never exceed
            seg_left = 0;
            for (n = 0; n < PHASE_WORDS; n++) begin
                // runs of load and no-load, with some noise words mixed in
                if (seg_left == 0) begin
                    if ($urandom_range(0, 4) != 0)
                        seg_high = !seg_high;
                    seg_left = $urandom_range(1, 60);
                end
                seg_left--;
                if ($urandom_range(0, 9) == 0)
                    w.cur = CUR_W'($urandom_range(0, 1023));
                else if (seg_high)
                    w.cur = (s.run_cur == 10'd1023) ? 10'd1023 :
                            CUR_W'($urandom_range(32'(s.run_cur) + 1, 1023));
                else
                    w.cur = CUR_W'($urandom_range(0, 32'(s.run_cur)));
                w.tick   = 1'($urandom_range(0, 1));
                w.stored = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 6) == 0)
                    w.idx = IDX_W'($urandom_range(10, 15));
                else
                    w.idx = IDX_W'($urandom_range(0, HIST_DEPTH - 1));
                push_word(w, 1'b0);
            end
        end

        // all words in: wait for the tail and let the pipe settle
        tx_steady = 1'b0;
        drain_results();

        $display("covered %0d samples under %0d register settings, %0d pump starts",
                 n_words, n_settings, m_starts);
        $display("alarm store requests seen: %0d, mismatches: %0d",
                 n_store_reqs, err_count);
        if (err_count == 0 && pump_status_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
rtl/prm_pkg.sv
rtl/pump_run_monitor.sv
tb/tb_pump_run_monitor.sv
